// ===== src/tdkr_pkg.sv =====
// Shared types and constants for the tap dance key resolver.
package tdkr_pkg;

    localparam logic [4:0] MAX_PAIRS = 5'd16;
    localparam int RES_MAX = 3;

    localparam logic [2:0] ACT_PRESS       = 3'd0;
    localparam logic [2:0] ACT_RELEASE     = 3'd1;
    localparam logic [2:0] ACT_TICK        = 3'd2;
    localparam logic [2:0] ACT_OTHER_PRESS = 3'd3;
    localparam logic [2:0] ACT_MOUSE_MOVE  = 3'd4;
    localparam logic [2:0] ACT_CAPT_REL    = 3'd5;

    localparam logic [2:0] REG_PAIR_COUNT   = 3'd0;
    localparam logic [2:0] REG_TAPPING_TERM = 3'd1;
    localparam logic [2:0] REG_MOTION_LIMIT = 3'd2;
    localparam logic [2:0] REG_BALANCED_MODE = 3'd3;
    localparam logic [2:0] REG_POINTER_MASK = 3'd4;

    typedef enum logic [1:0] {
        TK_TAP     = 2'd0,
        TK_HOLD    = 2'd1,
        TK_OTHER   = 2'd2,
        TK_CAPTURE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_PRESSED     = 3'd1,
        PH_TAP_OR_NEXT = 3'd2,
        PH_HOLD        = 3'd3,
        PH_HOOK        = 3'd4
    } phase_t;

    typedef struct packed {
        logic [4:0]  pair_count;
        logic [15:0] tapping_term;
        logic [15:0] motion_limit;
        logic        balanced_mode;
        logic [63:0] pointer_mask;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         other_key;
        logic [5:0]         pointer_id;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] index;
        logic [7:0] key;
        logic       press;
    } res_t;

    typedef res_t [RES_MAX-1:0] res_vec_t;

    typedef struct packed {
        logic set_down;
        logic clr_down;
        logic start_seq;
        logic to_pressed;
        logic to_tap_next;
        logic tick;
        logic disarm;
        logic upd_sums;
        logic capture;
        logic tap;
        logic hold;
        logic hold_rel;
        logic other_press;
        logic other_rel;
    } dec_t;

endpackage

// ===== src/tdkr_core.sv =====
// Resolver state and the decision logic applied to one word per load.
module tdkr_core
    import tdkr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  cfg_t       cfg,
    input  item_t      item,
    output res_vec_t   res,
    output logic [1:0] res_count
);

    phase_t             phase_reg, phase_next;
    logic               pc_valid_reg, pc_valid_next;
    logic [3:0]         pc_reg, pc_next;
    logic [3:0]         hold_index_reg, hold_index_next;
    logic               listening_reg, listening_next;
    logic               down_reg, down_next;
    logic [15:0]        timer_reg, timer_next;
    logic               armed_reg, armed_next;
    logic signed [15:0] sum_x_reg, sum_x_next;
    logic signed [15:0] sum_y_reg, sum_y_next;
    logic [7:0]         capt_reg, capt_next;

    dec_t               dec;
    logic [4:0]         pairs;
    logic [3:0]         last_idx;
    logic [3:0]         cur_idx;
    logic [15:0]        timer_dec;
    logic [15:0]        term;
    logic signed [15:0] sx_new, sy_new;
    logic [16:0]        sx_sum, sy_sum, ax, ay;
    logic               moved;
    logic               hook_same;

    always_comb
    begin
        if (cfg.pair_count == 5'd0)
        begin
            pairs = 5'd1;
        end
        else if (cfg.pair_count > MAX_PAIRS)
        begin
            pairs = MAX_PAIRS;
        end
        else
        begin
            pairs = cfg.pair_count;
        end
        last_idx = 4'(pairs - 5'd1);
        if (!pc_valid_reg)
        begin
            cur_idx = 4'd0;
        end
        else if (pc_reg > last_idx)
        begin
            cur_idx = last_idx;
        end
        else
        begin
            cur_idx = pc_reg;
        end
        term      = (cfg.tapping_term == 16'd0) ? 16'd1 : cfg.tapping_term;
        timer_dec = timer_reg - 16'd1;
        hook_same = (phase_reg == PH_HOOK) && (item.other_key == capt_reg);
    end

    always_comb
    begin
        sx_sum = {sum_x_reg[15], sum_x_reg} + {item.delta_x[15], item.delta_x};
        sy_sum = {sum_y_reg[15], sum_y_reg} + {item.delta_y[15], item.delta_y};
        if (sx_sum[16] != sx_sum[15])
        begin
            sx_new = sx_sum[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            sx_new = sx_sum[15:0];
        end
        if (sy_sum[16] != sy_sum[15])
        begin
            sy_new = sy_sum[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            sy_new = sy_sum[15:0];
        end
        ax    = sx_new[15] ? (17'd0 - {sx_new[15], sx_new}) : {1'b0, sx_new};
        ay    = sy_new[15] ? (17'd0 - {sy_new[15], sy_new}) : {1'b0, sy_new};
        moved = (ax >= {1'b0, cfg.motion_limit}) || (ay >= {1'b0, cfg.motion_limit});
    end

    // Decision for the current word.
    always_comb
    begin
        dec = '0;
        case (item.action)
            ACT_PRESS:
            begin
                if (!down_reg)
                begin
                    dec.set_down = 1'b1;
                    dec.start_seq = (phase_reg == PH_IDLE);
                    dec.to_pressed = (phase_reg == PH_IDLE) || (phase_reg == PH_TAP_OR_NEXT);
                end
            end
            ACT_RELEASE:
            begin
                if (down_reg)
                begin
                    dec.clr_down = 1'b1;
                    case (phase_reg)
                        PH_HOLD:
                        begin
                            dec.hold_rel = 1'b1;
                        end
                        PH_PRESSED:
                        begin
                            if (pc_valid_reg && (pc_reg >= last_idx))
                            begin
                                dec.tap = 1'b1;
                            end
                            else
                            begin
                                dec.to_tap_next = 1'b1;
                            end
                        end
                        PH_HOOK:
                        begin
                            dec.tap = 1'b1;
                            dec.other_press = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ACT_TICK:
            begin
                if (armed_reg)
                begin
                    dec.tick = 1'b1;
                    if (timer_dec == 16'd0)
                    begin
                        dec.disarm = 1'b1;
                        case (phase_reg)
                            PH_PRESSED:
                            begin
                                dec.hold = 1'b1;
                            end
                            PH_TAP_OR_NEXT:
                            begin
                                dec.tap = 1'b1;
                            end
                            PH_HOOK:
                            begin
                                dec.hold = 1'b1;
                                dec.other_press = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ACT_OTHER_PRESS:
            begin
                if (listening_reg && !hook_same)
                begin
                    case (phase_reg)
                        PH_PRESSED:
                        begin
                            dec.capture = cfg.balanced_mode;
                            dec.hold = !cfg.balanced_mode;
                        end
                        PH_TAP_OR_NEXT:
                        begin
                            dec.tap = 1'b1;
                        end
                        PH_HOOK:
                        begin
                            dec.hold = 1'b1;
                            dec.other_press = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ACT_MOUSE_MOVE:
            begin
                if (listening_reg && cfg.pointer_mask[item.pointer_id])
                begin
                    dec.upd_sums = 1'b1;
                    if (moved)
                    begin
                        dec.hold = (phase_reg == PH_PRESSED);
                        dec.tap = (phase_reg == PH_TAP_OR_NEXT);
                    end
                end
            end
            ACT_CAPT_REL:
            begin
                if (hook_same)
                begin
                    dec.hold = 1'b1;
                    dec.other_press = 1'b1;
                    dec.other_rel = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next      = phase_reg;
        pc_valid_next   = pc_valid_reg;
        pc_next         = pc_reg;
        hold_index_next = hold_index_reg;
        listening_next  = listening_reg;
        down_next       = down_reg;
        timer_next      = timer_reg;
        armed_next      = armed_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        capt_next       = capt_reg;
        if (dec.set_down)
        begin
            down_next = 1'b1;
        end
        if (dec.clr_down)
        begin
            down_next = 1'b0;
        end
        if (dec.start_seq)
        begin
            listening_next = 1'b1;
            sum_x_next = '0;
            sum_y_next = '0;
        end
        if (dec.to_pressed)
        begin
            phase_next = PH_PRESSED;
            if (!pc_valid_reg)
            begin
                pc_valid_next = 1'b1;
                pc_next = 4'd0;
            end
            else if (pc_reg < last_idx)
            begin
                pc_next = pc_reg + 4'd1;
            end
            timer_next = term;
            armed_next = 1'b1;
        end
        if (dec.to_tap_next)
        begin
            phase_next = PH_TAP_OR_NEXT;
            timer_next = term;
            armed_next = 1'b1;
        end
        if (dec.tick)
        begin
            timer_next = timer_dec;
        end
        if (dec.disarm)
        begin
            armed_next = 1'b0;
        end
        if (dec.upd_sums)
        begin
            sum_x_next = sx_new;
            sum_y_next = sy_new;
        end
        if (dec.capture)
        begin
            phase_next = PH_HOOK;
            capt_next = item.other_key;
        end
        if (dec.tap)
        begin
            phase_next = PH_IDLE;
            pc_valid_next = 1'b0;
            listening_next = 1'b0;
        end
        if (dec.hold)
        begin
            phase_next = PH_HOLD;
            hold_index_next = cur_idx;
            pc_valid_next = 1'b0;
        end
        if (dec.hold_rel)
        begin
            phase_next = PH_IDLE;
            listening_next = 1'b0;
        end
    end

    // Result words, in the order they are sent.
    always_comb
    begin
        res       = '0;
        res_count = 2'd0;
        if (dec.tap)
        begin
            res[0] = '{kind: TK_TAP, index: cur_idx, key: 8'd0, press: 1'b1};
            res[1] = '{kind: TK_TAP, index: cur_idx, key: 8'd0, press: 1'b0};
            res_count = 2'd2;
            if (dec.other_press)
            begin
                res[2] = '{kind: TK_OTHER, index: 4'd0, key: capt_reg, press: 1'b1};
                res_count = 2'd3;
            end
        end
        else if (dec.hold)
        begin
            res[0] = '{kind: TK_HOLD, index: cur_idx, key: 8'd0, press: 1'b1};
            res_count = 2'd1;
            if (dec.other_press)
            begin
                res[1] = '{kind: TK_OTHER, index: 4'd0, key: capt_reg, press: 1'b1};
                res_count = 2'd2;
                if (dec.other_rel)
                begin
                    res[2] = '{kind: TK_OTHER, index: 4'd0, key: capt_reg, press: 1'b0};
                    res_count = 2'd3;
                end
            end
        end
        else if (dec.hold_rel)
        begin
            res[0] = '{kind: TK_HOLD, index: hold_index_reg, key: 8'd0, press: 1'b0};
            res_count = 2'd1;
        end
        else if (dec.capture)
        begin
            res[0] = '{kind: TK_CAPTURE, index: 4'd0, key: item.other_key, press: 1'b1};
            res_count = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pc_valid_reg   <= 1'b0;
            pc_reg         <= 4'd0;
            hold_index_reg <= 4'd0;
            listening_reg  <= 1'b0;
            down_reg       <= 1'b0;
            timer_reg      <= 16'd0;
            armed_reg      <= 1'b0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            capt_reg       <= 8'd0;
        end
        else if (load)
        begin
            phase_reg      <= phase_next;
            pc_valid_reg   <= pc_valid_next;
            pc_reg         <= pc_next;
            hold_index_reg <= hold_index_next;
            listening_reg  <= listening_next;
            down_reg       <= down_next;
            timer_reg      <= timer_next;
            armed_reg      <= armed_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            capt_reg       <= capt_next;
        end
    end

endmodule

// ===== src/tdkr_outbuf.sv =====
// Result buffer that sends up to three result words, one per cycle while the receiver is ready.
module tdkr_outbuf
    import tdkr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load_req,
    input  res_vec_t   load_res,
    input  logic [1:0] load_count,
    output logic       load_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res,
    output logic       out_last
);

    res_vec_t   res_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;
    logic       do_load;

    assign pop       = out_valid && out_ready;
    assign load_ok   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign do_load   = load_req && load_ok;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = res_reg[0];
    assign out_last  = (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_load)
        begin
            cnt_next = load_count;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            res_reg <= load_res;
        end
        else if (pop)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

endmodule

// ===== src/tap_dance_key_resolver_top.sv =====
// Top level of the tap dance key resolver: registers, input stage and result buffer.
//
// Input words (press, release, tick, other key press, mouse move, captured key
// release) arrive on a valid/ready channel and are registered on acceptance.
// The registered word is resolved against the key state in one pass, and its
// zero to three result words are loaded into the result buffer when it can
// take them. Result words leave on a second valid/ready channel, one per cycle
// while the receiver is ready, with last marking the final word caused by an
// input word. The first result word is offered once its input word has been
// resolved and loaded into the result buffer.
// While the receiver is ready, an input word that gives at most one result can
// be accepted in every cycle; words giving more are limited by the result
// buffer, which sends one word per cycle and reloads only as its last word leaves.
// When the receiver stalls, the buffer holds its words and the input stage
// holds one more word, after which in_ready falls.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// while the block is idle, which the user must keep; the block does not enforce
// it. Reset restores the register defaults, idles the key and empties both stages.
module tap_dance_key_resolver_top
    import tdkr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic [7:0]         other_key,
    input  logic [5:0]         pointer_id,
    input  logic signed [15:0] delta_x,
    input  logic signed [15:0] delta_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         target_kind,
    output logic [3:0]         target_index,
    output logic [7:0]         target_key,
    output logic               is_press,
    output logic               last
);

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       item_valid_reg, item_valid_next;
    logic       in_fire;
    logic       load_ok;
    res_vec_t   core_res;
    logic [1:0] core_count;
    res_t       out_res;

    assign in_ready = !item_valid_reg || load_ok;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_fire)
        begin
            item_valid_next = 1'b1;
        end
        else if (load_ok)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= '{action: action, other_key: other_key, pointer_id: pointer_id,
                          delta_x: delta_x, delta_y: delta_y};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pair_count    <= 5'd1;
            cfg_reg.tapping_term  <= 16'd200;
            cfg_reg.motion_limit  <= 16'd10;
            cfg_reg.balanced_mode <= 1'b0;
            cfg_reg.pointer_mask  <= 64'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PAIR_COUNT:    cfg_reg.pair_count    <= cfg_data[4:0];
                REG_TAPPING_TERM:  cfg_reg.tapping_term  <= cfg_data[15:0];
                REG_MOTION_LIMIT:  cfg_reg.motion_limit  <= cfg_data[15:0];
                REG_BALANCED_MODE: cfg_reg.balanced_mode <= cfg_data[0];
                REG_POINTER_MASK:  cfg_reg.pointer_mask  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tdkr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (item_valid_reg && load_ok),
        .cfg       (cfg_reg),
        .item      (item_reg),
        .res       (core_res),
        .res_count (core_count)
    );

    tdkr_outbuf u_outbuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_req   (item_valid_reg),
        .load_res   (core_res),
        .load_count (core_count),
        .load_ok    (load_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res),
        .out_last   (last)
    );

    assign target_kind  = out_res.kind;
    assign target_index = out_res.index;
    assign target_key   = out_res.key;
    assign is_press     = out_res.press;

endmodule

// ===== bench/tdkr_resolve_check.sv =====
`timescale 1ns / 100ps
// Channel monitor for the tap dance key resolver: predicts every result word and compares it.
module tdkr_resolve_check
    import tdkr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         action,
    input  logic [7:0]         other_key,
    input  logic [5:0]         pointer_id,
    input  logic signed [15:0] delta_x,
    input  logic signed [15:0] delta_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         target_kind,
    input  logic [3:0]         target_index,
    input  logic [7:0]         target_key,
    input  logic               is_press,
    input  logic               last,
    output int                 fail_count,
    output int                 pending
);

    localparam int REPORT_LINES = 40;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] index;
        logic [7:0] key;
        logic       press;
        logic       last;
    } keystroke_t;

    cfg_t        cfg;
    phase_t      phase;
    int          press_cnt;
    logic [3:0]  hold_idx;
    logic        listening;
    logic        key_down;
    logic [15:0] timer_left;
    logic        timer_armed;
    int          sum_x;
    int          sum_y;
    int          mag_x;
    int          mag_y;
    logic [7:0]  captured;
    keystroke_t  awaited[$];
    keystroke_t  burst[$];
    keystroke_t  seen;
    int          mismatches = 0;

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LINES)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic int pairs_used();
        if (cfg.pair_count == 5'd0)
            return 1;
        if (cfg.pair_count > MAX_PAIRS)
            return int'(MAX_PAIRS);
        return int'(cfg.pair_count);
    endfunction

    function automatic logic [3:0] pair_index();
        if (press_cnt < 0)
            return 4'd0;
        if (press_cnt > pairs_used() - 1)
            return 4'(pairs_used() - 1);
        return 4'(press_cnt);
    endfunction

    function automatic int clamp16(input int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    task automatic add_stroke(input kind_t k, input logic [3:0] idx, input logic [7:0] key,
                              input logic press);
        keystroke_t w;
        w.kind = k;
        w.index = idx;
        w.key = key;
        w.press = press;
        w.last = 1'b0;
        burst = {burst, w};
    endtask

    task automatic restart_timer();
        timer_left = (cfg.tapping_term == 16'd0) ? 16'd1 : cfg.tapping_term;
        timer_armed = 1'b1;
    endtask

    task automatic tap_pair();
        logic [3:0] idx;
        idx = pair_index();
        phase = PH_IDLE;
        add_stroke(TK_TAP, idx, 8'd0, 1'b1);
        add_stroke(TK_TAP, idx, 8'd0, 1'b0);
        press_cnt = -1;
        listening = 1'b0;
    endtask

    task automatic begin_hold();
        phase = PH_HOLD;
        hold_idx = pair_index();
        press_cnt = -1;
        add_stroke(TK_HOLD, hold_idx, 8'd0, 1'b1);
    endtask

    task automatic end_hold();
        phase = PH_IDLE;
        add_stroke(TK_HOLD, hold_idx, 8'd0, 1'b0);
        listening = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.pair_count = 5'd1;
            cfg.tapping_term = 16'd200;
            cfg.motion_limit = 16'd10;
            cfg.balanced_mode = 1'b0;
            cfg.pointer_mask = 64'd0;
            phase = PH_IDLE;
            press_cnt = -1;
            hold_idx = 4'd0;
            listening = 1'b0;
            key_down = 1'b0;
            timer_left = 16'd0;
            timer_armed = 1'b0;
            sum_x = 0;
            sum_y = 0;
            captured = 8'd0;
            awaited.delete();
            pending <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                    report_mismatch($sformatf("result word kind %0d index %0d key %0d with none expected",
                                              target_kind, target_index, target_key));
                else
                begin
                    seen = awaited.pop_front();
                    if (target_kind != seen.kind)
                        report_mismatch($sformatf("target_kind %0d, expected %0d",
                                                  target_kind, seen.kind));
                    if (target_index != seen.index)
                        report_mismatch($sformatf("target_index %0d, expected %0d",
                                                  target_index, seen.index));
                    if (target_key != seen.key)
                        report_mismatch($sformatf("target_key %0d, expected %0d",
                                                  target_key, seen.key));
                    if (is_press != seen.press)
                        report_mismatch($sformatf("is_press %0d, expected %0d",
                                                  is_press, seen.press));
                    if (last != seen.last)
                        report_mismatch($sformatf("last %0d, expected %0d", last, seen.last));
                end
            end

            if (cfg_write)
                case (cfg_index)
                    REG_PAIR_COUNT:    cfg.pair_count = cfg_data[4:0];
                    REG_TAPPING_TERM:  cfg.tapping_term = cfg_data[15:0];
                    REG_MOTION_LIMIT:  cfg.motion_limit = cfg_data[15:0];
                    REG_BALANCED_MODE: cfg.balanced_mode = cfg_data[0];
                    REG_POINTER_MASK:  cfg.pointer_mask = cfg_data;
                    default: ;
                endcase

            if (in_valid && in_ready)
            begin
                burst.delete();
                case (action)
                    ACT_PRESS:
                        if (!key_down)
                        begin
                            key_down = 1'b1;
                            if (phase == PH_IDLE)
                            begin
                                listening = 1'b1;
                                sum_x = 0;
                                sum_y = 0;
                            end
                            if (phase == PH_IDLE || phase == PH_TAP_OR_NEXT)
                            begin
                                phase = PH_PRESSED;
                                if (press_cnt < pairs_used() - 1)
                                    press_cnt++;
                                restart_timer();
                            end
                        end
                    ACT_RELEASE:
                        if (key_down)
                        begin
                            key_down = 1'b0;
                            case (phase)
                                PH_HOLD:
                                    end_hold();
                                PH_PRESSED:
                                    if (press_cnt >= pairs_used() - 1)
                                        tap_pair();
                                    else
                                    begin
                                        phase = PH_TAP_OR_NEXT;
                                        restart_timer();
                                    end
                                PH_HOOK:
                                begin
                                    tap_pair();
                                    add_stroke(TK_OTHER, 4'd0, captured, 1'b1);
                                end
                                default: ;
                            endcase
                        end
                    ACT_TICK:
                        if (timer_armed)
                        begin
                            timer_left = timer_left - 16'd1;
                            if (timer_left == 16'd0)
                            begin
                                timer_armed = 1'b0;
                                case (phase)
                                    PH_PRESSED:
                                        begin_hold();
                                    PH_TAP_OR_NEXT:
                                        tap_pair();
                                    PH_HOOK:
                                    begin
                                        begin_hold();
                                        add_stroke(TK_OTHER, 4'd0, captured, 1'b1);
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    ACT_OTHER_PRESS:
                        if (listening && !(phase == PH_HOOK && other_key == captured))
                            case (phase)
                                PH_PRESSED:
                                    if (cfg.balanced_mode)
                                    begin
                                        phase = PH_HOOK;
                                        captured = other_key;
                                        add_stroke(TK_CAPTURE, 4'd0, other_key, 1'b1);
                                    end
                                    else
                                        begin_hold();
                                PH_TAP_OR_NEXT:
                                    tap_pair();
                                PH_HOOK:
                                begin
                                    begin_hold();
                                    add_stroke(TK_OTHER, 4'd0, captured, 1'b1);
                                end
                                default: ;
                            endcase
                    ACT_MOUSE_MOVE:
                        if (listening && cfg.pointer_mask[pointer_id])
                        begin
                            sum_x = clamp16(sum_x + int'(delta_x));
                            sum_y = clamp16(sum_y + int'(delta_y));
                            mag_x = (sum_x < 0) ? -sum_x : sum_x;
                            mag_y = (sum_y < 0) ? -sum_y : sum_y;
                            if (mag_x >= int'(cfg.motion_limit)
                                || mag_y >= int'(cfg.motion_limit))
                            begin
                                if (phase == PH_PRESSED)
                                    begin_hold();
                                else if (phase == PH_TAP_OR_NEXT)
                                    tap_pair();
                            end
                        end
                    ACT_CAPT_REL:
                        if (phase == PH_HOOK && other_key == captured)
                        begin
                            begin_hold();
                            add_stroke(TK_OTHER, 4'd0, captured, 1'b1);
                            add_stroke(TK_OTHER, 4'd0, captured, 1'b0);
                        end
                    default: ;
                endcase
                if (burst.size() != 0)
                    burst[burst.size() - 1].last = 1'b1;
                awaited = {awaited, burst};
            end

            pending <= awaited.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== bench/tap_dance_key_resolver_top_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the tap dance key resolver: clock, reset, stimulus, idling and verdict.
module tap_dance_key_resolver_top_test;
    import tdkr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_WORDS    = 72;
    localparam int RANDOM_PHASES   = 6;
    localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = 3'd0;
    logic [63:0]        cfg_data = 64'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         action = 3'd0;
    logic [7:0]         other_key = 8'd0;
    logic [5:0]         pointer_id = 6'd0;
    logic signed [15:0] delta_x = 16'sd0;
    logic signed [15:0] delta_y = 16'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         target_kind;
    logic [3:0]         target_index;
    logic [7:0]         target_key;
    logic               is_press;
    logic               last;
    int                 fail_count;
    int                 pending;

    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    tap_dance_key_resolver_top dut (.*);

    tdkr_resolve_check resolve_check (.*);

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [4:0] pairs, input logic [15:0] term,
                                  input logic [15:0] thresh, input logic balanced,
                                  input logic [63:0] mask);
        write_reg(REG_PAIR_COUNT, 64'(pairs));
        write_reg(REG_TAPPING_TERM, 64'(term));
        write_reg(REG_MOTION_LIMIT, 64'(thresh));
        write_reg(REG_BALANCED_MODE, 64'(balanced));
        write_reg(REG_POINTER_MASK, mask);
        cfg_write <= 1'b0;
    endtask

    // Valid stays high from one word to the next unless an idle gap is drawn.
    task automatic send_word(input logic [2:0] act, input logic [7:0] key,
                             input logic [5:0] mid, input logic signed [15:0] dx,
                             input logic signed [15:0] dy);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        action <= act;
        other_key <= key;
        pointer_id <= mid;
        delta_x <= dx;
        delta_y <= dy;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        do
        begin
            while (pending != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (pending != 0);
    endtask

    initial
    begin
        int                 sent;
        int                 pick;
        logic [2:0]         word_act;
        logic [7:0]         word_key;
        logic [5:0]         word_mouse;
        logic signed [15:0] word_dx;
        logic signed [15:0] word_dy;
        logic [7:0]         recent_key;

        recent_key = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(5'd3, 16'd2, 16'hFFFF, 1'b1, '1);
        send_word(ACT_RELEASE, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_PRESS, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_PRESS, 8'hFF, 6'd63, 16'sd0, 16'sd0);
        send_word(ACT_MOUSE_MOVE, 8'h00, 6'd63, 16'sh8000, 16'sh7FFF);
        send_word(ACT_MOUSE_MOVE, 8'hFF, 6'd0, 16'sh8000, 16'sh8000);
        send_word(ACT_OTHER_PRESS, 8'hFF, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_OTHER_PRESS, 8'hFF, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_CAPT_REL, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_CAPT_REL, 8'hFF, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_TICK, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_TICK, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_RELEASE, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_CAPT_REL, 8'hFF, 6'd0, 16'sd0, 16'sd0);
        repeat (3)
        begin
            send_word(ACT_PRESS, 8'h00, 6'd0, 16'sd0, 16'sd0);
            send_word(ACT_RELEASE, 8'h00, 6'd0, 16'sd0, 16'sd0);
        end
        send_word(ACT_UNUSED_6, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_UNUSED_7, 8'hFF, 6'd63, 16'shFFFF, 16'shFFFF);

        wait_quiet();
        apply_settings(5'd4, 16'd1, 16'd0, 1'b0, 64'h8000_0000_0000_0001);
        send_word(ACT_PRESS, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_RELEASE, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_PRESS, 8'h00, 6'd0, 16'sd0, 16'sd0);
        // The pair count now shrinks under a running sequence.
        wait_quiet();
        apply_settings(5'd1, 16'd1, 16'd0, 1'b0, 64'h8000_0000_0000_0001);
        send_word(ACT_RELEASE, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_PRESS, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_MOUSE_MOVE, 8'h00, 6'd5, 16'sd1, 16'sd1);
        send_word(ACT_MOUSE_MOVE, 8'h00, 6'd63, 16'sd0, 16'sd0);
        send_word(ACT_TICK, 8'h00, 6'd0, 16'sd0, 16'sd0);
        send_word(ACT_RELEASE, 8'h00, 6'd0, 16'sd0, 16'sd0);

        // The receiver holds off while taps keep arriving, so the block fills up.
        wait_quiet();
        apply_settings(5'd1, 16'd4, 16'hFFFF, 1'b0, 64'd0);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (10)
        begin
            send_word(ACT_PRESS, 8'($urandom_range(255)), 6'($urandom_range(63)),
                      16'($urandom), 16'($urandom));
            send_word(ACT_RELEASE, 8'($urandom_range(255)), 6'($urandom_range(63)),
                      16'($urandom), 16'($urandom));
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_quiet();
            case (p)
                0: apply_settings(5'd2, 16'd3, 16'd40, 1'b1, '1);
                1: apply_settings(5'd16, 16'd2, 16'd0, 1'b1, {$urandom, $urandom});
                2: apply_settings(5'd0, 16'd0, 16'hFFFF, 1'b0, 64'd1);
                3: apply_settings(5'd31, 16'hFFFF, 16'd300, 1'b1, '1);
                4: apply_settings(5'd3, 16'd1, 16'd100, 1'b0, {$urandom, $urandom});
                default: apply_settings(5'd5, 16'd4, 16'd20, 1'b1, '1);
            endcase
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 81;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 81;
                end
                default:
                begin
                    idle_pct = 7;
                    stall_pct <= 7;
                end
            endcase

            sent = 0;
            while (sent < RANDOM_WORDS / RANDOM_PHASES)
            begin
                pick = $urandom_range(99);
                word_key = 8'($urandom_range(255));
                word_mouse = 6'($urandom_range(63));
                if ($urandom_range(7) == 0)
                begin
                    word_dx = 16'($urandom);
                    word_dy = 16'($urandom);
                end
                else
                begin
                    word_dx = 16'(int'($urandom_range(160)) - 80);
                    word_dy = 16'(int'($urandom_range(160)) - 80);
                end
                if (pick < 22)
                    word_act = ACT_PRESS;
                else if (pick < 42)
                    word_act = ACT_RELEASE;
                else if (pick < 66)
                    word_act = ACT_TICK;
                else if (pick < 78)
                begin
                    word_act = ACT_OTHER_PRESS;
                    if ($urandom_range(3) == 0)
                        word_key = recent_key;
                    recent_key = word_key;
                end
                else if (pick < 90)
                    word_act = ACT_MOUSE_MOVE;
                else if (pick < 98)
                begin
                    word_act = ACT_CAPT_REL;
                    if ($urandom_range(3) != 0)
                        word_key = recent_key;
                end
                else
                    word_act = pick[0] ? ACT_UNUSED_7 : ACT_UNUSED_6;
                send_word(word_act, word_key, word_mouse, word_dx, word_dy);
                if (word_act <= ACT_CAPT_REL)
                    sent++;
            end
        end

        wait_quiet();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
